// ===== rtl/core/rcd_pkg.sv =====
// Rolling counter display: shared widths, constants, payload structs, the
// counter step helper and constant-divide helpers. No dependencies.
package rcd_pkg;

    localparam int LEVEL_W      = 10;
    localparam int SCORE_W      = 20;
    localparam int FLASH_W      = 6;
    localparam int FRAME_W      = 5;
    localparam int DIGIT_W      = 4;
    localparam int CFG_DATA_W   = 10;
    localparam int DIGIT_STAGES = 5;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 10'd999;
    localparam logic [SCORE_W-1:0] SCORE_MAX    = 20'd999999;
    localparam logic [LEVEL_W-1:0] THRESH_RESET = 10'd25;
    localparam logic [FLASH_W-1:0] FLASH_RESET  = 6'd40;

    // n / 6 as (n * ceil(2^24 / 6)) >> 24, exact for n < 2^23
    localparam logic [21:0] DIV6_MUL    = 22'd2796203;
    localparam int          DIV6_SHIFT  = 24;
    // n / 10 as (n * ceil(2^23 / 10)) >> 23, exact for n < 2^22
    localparam logic [19:0] DIV10_MUL   = 20'd838861;
    localparam int          DIV10_SHIFT = 23;
    // n / 10 as (n * 205) >> 11, exact for n < 1029
    localparam logic [7:0]  LDIV10_MUL   = 8'd205;
    localparam int          LDIV10_SHIFT = 11;

    typedef enum logic [0:0] {
        CFG_LOW_LEVEL = 1'b0,
        CFG_FLASH_LEN = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [SCORE_W-1:0] score;
        logic               vis;
        logic               lredraw;
        logic               sredraw;
    } t_frame;

    typedef struct packed {
        logic [LEVEL_W-1:0]                   lvl_rem;
        logic [SCORE_W-1:0]                   scr_rem;
        logic [DIGIT_STAGES-1:0][DIGIT_W-1:0] lvl_dig;
        logic [DIGIT_STAGES-1:0][DIGIT_W-1:0] scr_dig;
        logic                                 vis;
        logic                                 lredraw;
        logic                                 sredraw;
    } t_digits;

    function automatic logic [SCORE_W-1:0] move_toward(input logic [SCORE_W-1:0] cur,
                                                       input logic [SCORE_W-1:0] goal);
        logic signed [SCORE_W:0] diff;
        logic [SCORE_W-1:0]      mag;
        logic [41:0]             prod;
        logic [SCORE_W-1:0]      step;
        diff = $signed({1'b0, goal}) - $signed({1'b0, cur});
        mag  = diff[SCORE_W] ? SCORE_W'(-diff) : diff[SCORE_W-1:0];
        prod = {22'd0, mag} * {20'd0, DIV6_MUL};
        step = SCORE_W'(prod >> DIV6_SHIFT);
        if (step == '0) begin
            step = SCORE_W'(1);
        end
        if (diff == '0) begin
            move_toward = cur;
        end else if (diff[SCORE_W]) begin
            move_toward = cur - step;
        end else begin
            move_toward = cur + step;
        end
    endfunction

    function automatic logic [SCORE_W-1:0] div10(input logic [SCORE_W-1:0] n);
        logic [39:0] prod;
        prod  = {20'd0, n} * {20'd0, DIV10_MUL};
        div10 = SCORE_W'(prod >> DIV10_SHIFT);
    endfunction

    function automatic logic [LEVEL_W-1:0] ldiv10(input logic [LEVEL_W-1:0] n);
        logic [17:0] prod;
        prod   = {8'd0, n} * {10'd0, LDIV10_MUL};
        ldiv10 = LEVEL_W'(prod >> LDIV10_SHIFT);
    endfunction

endpackage

// ===== rtl/core/rolling_counter_display.sv =====
// Rolling counter display top level: frame update followed by a chain of
// decimal conversion stages. Depends on rcd_pkg, rcd_frame_update, rcd_digit_stage.
//
// Usage:
//   Input channel i_in_valid/o_in_ready carries one frame: raw level, raw
//   score and the restart flag. Output channel o_out_valid/i_out_ready
//   carries the decimal digits of the shown level and score, the level
//   visibility bit and the two redraw flags, one result per frame.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data):
//   index 0 is the low-level blink threshold, index 1 the fast-blink length.
//   Write it only while no frame is in flight.
//   From input transfer to output valid a frame passes seven registers:
//   input register, counter update register, five digit stages.
//   Throughput: one frame per cycle while the receiver takes results; the
//   per-frame counter step with its divide-by-6 multiply is combinational.
//   Reset (synchronous, active low) clears the shown counters, the blink
//   and frame counters and the loaded flag, and empties the pipeline.
//   When the receiver stalls, each stage holds its item and the pipeline
//   keeps taking frames until every stage is full.
module rolling_counter_display (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  rcd_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [rcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [15:0]             i_level_raw,
    input  logic signed [23:0]             i_score_raw,
    input  logic                           i_restart,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [3:0]                     o_level_hundreds,
    output logic [3:0]                     o_level_tens,
    output logic [3:0]                     o_level_ones,
    output logic [3:0]                     o_score_d5,
    output logic [3:0]                     o_score_d4,
    output logic [3:0]                     o_score_d3,
    output logic [3:0]                     o_score_d2,
    output logic [3:0]                     o_score_d1,
    output logic [3:0]                     o_score_d0,
    output logic                           o_level_visible,
    output logic                           o_level_redraw,
    output logic                           o_score_redraw
);
    import rcd_pkg::*;

    logic    upd_valid;
    logic    upd_ready;
    t_frame  upd_frame;
    logic    stg_valid [DIGIT_STAGES+1];
    logic    stg_ready [DIGIT_STAGES+1];
    t_digits stg_data  [DIGIT_STAGES+1];
    t_digits last;

    rcd_frame_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_level_raw (i_level_raw),
        .i_score_raw (i_score_raw),
        .i_restart   (i_restart),
        .o_valid     (upd_valid),
        .o_frame     (upd_frame),
        .i_ready     (upd_ready)
    );

    always_comb begin
        stg_data[0]         = '0;
        stg_data[0].lvl_rem = upd_frame.level;
        stg_data[0].scr_rem = upd_frame.score;
        stg_data[0].vis     = upd_frame.vis;
        stg_data[0].lredraw = upd_frame.lredraw;
        stg_data[0].sredraw = upd_frame.sredraw;
    end

    assign stg_valid[0]            = upd_valid;
    assign upd_ready               = stg_ready[0];
    assign stg_ready[DIGIT_STAGES] = i_out_ready;

    for (genvar g = 0; g < DIGIT_STAGES; g++) begin : g_digit
        rcd_digit_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_data  (stg_data[g]),
            .o_valid (stg_valid[g+1]),
            .o_data  (stg_data[g+1]),
            .i_ready (stg_ready[g+1])
        );
    end

    assign last             = stg_data[DIGIT_STAGES];
    assign o_out_valid      = stg_valid[DIGIT_STAGES];
    assign o_level_hundreds = last.lvl_dig[2];
    assign o_level_tens     = last.lvl_dig[1];
    assign o_level_ones     = last.lvl_dig[0];
    assign o_score_d5       = last.scr_rem[DIGIT_W-1:0];
    assign o_score_d4       = last.scr_dig[4];
    assign o_score_d3       = last.scr_dig[3];
    assign o_score_d2       = last.scr_dig[2];
    assign o_score_d1       = last.scr_dig[1];
    assign o_score_d0       = last.scr_dig[0];
    assign o_level_visible  = last.vis;
    assign o_level_redraw   = last.lredraw;
    assign o_score_redraw   = last.sredraw;

endmodule

// ===== rtl/core/rcd_frame_update.sv =====
// Rolling counter display: input register, per-frame counter state and
// blink logic, frame result register. Depends on rcd_pkg.
module rcd_frame_update (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  rcd_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [rcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [15:0]             i_level_raw,
    input  logic signed [23:0]             i_score_raw,
    input  logic                           i_restart,
    output logic                           o_valid,
    output rcd_pkg::t_frame                o_frame,
    input  logic                           i_ready
);
    import rcd_pkg::*;

    logic [LEVEL_W-1:0] r_thresh;
    logic [FLASH_W-1:0] r_flash_len;

    logic               r_a_valid;
    logic [LEVEL_W-1:0] r_a_level;
    logic [SCORE_W-1:0] r_a_score;
    logic               r_a_restart;

    logic               r_b_valid;
    t_frame             r_b_frame;

    logic [LEVEL_W-1:0] r_level_shown;
    logic [LEVEL_W-1:0] r_level_target;
    logic [SCORE_W-1:0] r_score_shown;
    logic [FLASH_W-1:0] r_flash_count;
    logic [FRAME_W-1:0] r_frame_count;
    logic               r_loaded;

    logic [LEVEL_W-1:0] lvl_clamp;
    logic [SCORE_W-1:0] scr_clamp;
    logic               a_ready;
    logic               a_move;
    logic               eff_loaded;
    logic               drop;
    logic [FLASH_W-1:0] flash_base;
    logic [FLASH_W-1:0] flash_set;
    logic [FLASH_W-1:0] n_flash_count;
    logic [FRAME_W-1:0] n_frame_count;
    logic [LEVEL_W-1:0] lvl_mv;
    logic [SCORE_W-1:0] scr_mv;
    logic [LEVEL_W-1:0] n_level_shown;
    logic [SCORE_W-1:0] n_score_shown;
    t_frame             n_b_frame;

    always_comb begin
        if (i_level_raw[15]) begin
            lvl_clamp = '0;
        end else if ($unsigned(i_level_raw) > 16'(LEVEL_MAX)) begin
            lvl_clamp = LEVEL_MAX;
        end else begin
            lvl_clamp = i_level_raw[LEVEL_W-1:0];
        end
        if (i_score_raw[23]) begin
            scr_clamp = '0;
        end else if ($unsigned(i_score_raw) > 24'(SCORE_MAX)) begin
            scr_clamp = SCORE_MAX;
        end else begin
            scr_clamp = i_score_raw[SCORE_W-1:0];
        end
    end

    assign a_ready = !r_b_valid || i_ready;
    assign o_ready = !r_a_valid || a_ready;
    assign a_move  = r_a_valid && a_ready;

    always_comb begin
        eff_loaded    = r_loaded && !r_a_restart;
        flash_base    = r_a_restart ? '0 : r_flash_count;
        n_frame_count = r_frame_count + FRAME_W'(1);
        drop          = eff_loaded && (r_a_level < r_level_target);
        flash_set     = drop ? r_flash_len : flash_base;
        n_flash_count = (flash_set != '0) ? flash_set - FLASH_W'(1) : '0;

        lvl_mv = LEVEL_W'(move_toward(SCORE_W'(r_level_shown), SCORE_W'(r_a_level)));
        scr_mv = move_toward(r_score_shown, r_a_score);
        n_level_shown = eff_loaded ? lvl_mv : r_a_level;
        n_score_shown = eff_loaded ? scr_mv : r_a_score;

        n_b_frame.level   = n_level_shown;
        n_b_frame.score   = n_score_shown;
        n_b_frame.lredraw = !eff_loaded || (lvl_mv != r_level_shown);
        n_b_frame.sredraw = !eff_loaded || (scr_mv != r_score_shown);
        if (flash_set != '0) begin
            n_b_frame.vis = !n_flash_count[1];
        end else if (r_a_level != '0 && r_a_level <= r_thresh) begin
            n_b_frame.vis = !n_frame_count[FRAME_W-1];
        end else begin
            n_b_frame.vis = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh       <= THRESH_RESET;
            r_flash_len    <= FLASH_RESET;
            r_a_valid      <= 1'b0;
            r_b_valid      <= 1'b0;
            r_level_shown  <= '0;
            r_level_target <= '0;
            r_score_shown  <= '0;
            r_flash_count  <= '0;
            r_frame_count  <= '0;
            r_loaded       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LOW_LEVEL: r_thresh    <= i_cfg_data[LEVEL_W-1:0];
                    CFG_FLASH_LEN: r_flash_len <= i_cfg_data[FLASH_W-1:0];
                    default: ;
                endcase
            end
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (a_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (a_move) begin
                r_level_shown  <= n_level_shown;
                r_level_target <= r_a_level;
                r_score_shown  <= n_score_shown;
                r_flash_count  <= n_flash_count;
                r_frame_count  <= n_frame_count;
                r_loaded       <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_level   <= lvl_clamp;
            r_a_score   <= scr_clamp;
            r_a_restart <= i_restart;
        end
        if (a_move) begin
            r_b_frame <= n_b_frame;
        end
    end

    assign o_valid = r_b_valid;
    assign o_frame = r_b_frame;

endmodule

// ===== rtl/core/rcd_digit_stage.sv =====
// Rolling counter display: one decimal conversion stage, peels the low digit
// of the level and of the score. Depends on rcd_pkg.
module rcd_digit_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rcd_pkg::t_digits i_data,
    output logic             o_valid,
    output rcd_pkg::t_digits o_data,
    input  logic             i_ready
);
    import rcd_pkg::*;

    logic               r_valid;
    t_digits            r_data;
    t_digits            n_data;
    logic [SCORE_W-1:0] scr_q;
    logic [SCORE_W-1:0] scr_r;
    logic [LEVEL_W-1:0] lvl_q;
    logic [LEVEL_W-1:0] lvl_r;

    always_comb begin
        scr_q  = div10(i_data.scr_rem);
        scr_r  = i_data.scr_rem - (scr_q << 3) - (scr_q << 1);
        lvl_q  = ldiv10(i_data.lvl_rem);
        lvl_r  = i_data.lvl_rem - (lvl_q << 3) - (lvl_q << 1);
        n_data         = i_data;
        n_data.scr_rem = scr_q;
        n_data.lvl_rem = lvl_q;
        n_data.scr_dig = {scr_r[DIGIT_W-1:0], i_data.scr_dig[DIGIT_STAGES-1:1]};
        n_data.lvl_dig = {lvl_r[DIGIT_W-1:0], i_data.lvl_dig[DIGIT_STAGES-1:1]};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/rcd_checker.sv =====
// Rolling counter display: port-level checker and its bind to the top level.
// Depends on rolling_counter_display.
module rcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [3:0] o_level_hundreds,
    input logic [3:0] o_level_tens,
    input logic [3:0] o_level_ones,
    input logic [3:0] o_score_d5,
    input logic [3:0] o_score_d4,
    input logic [3:0] o_score_d3,
    input logic [3:0] o_score_d2,
    input logic [3:0] o_score_d1,
    input logic [3:0] o_score_d0,
    input logic       o_level_visible,
    input logic       o_level_redraw,
    input logic       o_score_redraw
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_level_hundreds <= 4'd9 && o_level_tens <= 4'd9 &&
                         o_level_ones <= 4'd9 && o_score_d5 <= 4'd9 &&
                         o_score_d4 <= 4'd9 && o_score_d3 <= 4'd9 &&
                         o_score_d2 <= 4'd9 && o_score_d1 <= 4'd9 &&
                         o_score_d0 <= 4'd9))
        else $error("digit out of decimal range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_score_d0) &&
            $stable(o_level_ones) && $stable(o_level_visible) &&
            $stable(o_level_redraw) && $stable(o_score_redraw))
        else $error("result changed while stalled");

endmodule

bind rolling_counter_display rcd_checker u_rcd_checker (.*);

// ===== tb/sv/rolling_counter_display_tb.sv =====
// Self-checking testbench for rolling_counter_display: directed frame table, then
// random frame sequences under several register settings, checked against a predictor.
// Depends on rcd_pkg and the rolling_counter_display RTL.
module rolling_counter_display_tb;
    import rcd_pkg::*;

    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int HOLD_OFF_CYCLES  = 160;
    localparam int DRAIN_PAUSE      = 10;
    localparam int RANDOM_PER_PHASE = 230;
    localparam int PHASES           = 8;
    localparam int DIRECTED_ROWS    = 21;

    typedef logic [0:11][3:0] t_disp;

    typedef struct packed {
        logic signed [15:0] lvl;
        logic signed [23:0] scr;
        logic               rst;
        logic               has_want;
        t_disp              want;
    } t_frame_row;

    localparam t_disp ALL_NINES = {{9{4'd9}}, 4'd1, 4'd1, 4'd1};
    localparam t_disp ALL_ZEROS = {{9{4'd0}}, 4'd1, 4'd1, 4'd1};

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    t_cfg_idx              i_cfg_idx   = CFG_LOW_LEVEL;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic signed [15:0]    i_level_raw = '0;
    logic signed [23:0]    i_score_raw = '0;
    logic                  i_restart   = 1'b0;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [3:0]            o_level_hundreds, o_level_tens, o_level_ones;
    logic [3:0]            o_score_d5, o_score_d4, o_score_d3;
    logic [3:0]            o_score_d2, o_score_d1, o_score_d0;
    logic                  o_level_visible, o_level_redraw, o_score_redraw;

    rolling_counter_display i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_level_raw      (i_level_raw),
        .i_score_raw      (i_score_raw),
        .i_restart        (i_restart),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_level_hundreds (o_level_hundreds),
        .o_level_tens     (o_level_tens),
        .o_level_ones     (o_level_ones),
        .o_score_d5       (o_score_d5),
        .o_score_d4       (o_score_d4),
        .o_score_d3       (o_score_d3),
        .o_score_d2       (o_score_d2),
        .o_score_d1       (o_score_d1),
        .o_score_d0       (o_score_d0),
        .o_level_visible  (o_level_visible),
        .o_level_redraw   (o_level_redraw),
        .o_score_redraw   (o_score_redraw)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state and register copies
    int         blink_thresh = 25;
    int         blink_len    = 40;
    int         lvl_now      = 0;
    int         lvl_goal     = 0;
    int         scr_now      = 0;
    int         scr_goal     = 0;
    logic [5:0] blink_left   = '0;
    logic [4:0] frame_no     = '0;
    logic       primed       = 1'b0;

    t_disp      pending_displays[$];
    int         mismatches   = 0;
    int         results_seen = 0;
    bit         steady       = 1'b0;
    int         walk_lvl     = 0;
    int         walk_scr     = 0;
    t_frame_row directed[DIRECTED_ROWS];

    string field_names [0:11] = '{"level_hundreds", "level_tens", "level_ones",
                                  "score_d5", "score_d4", "score_d3", "score_d2",
                                  "score_d1", "score_d0", "level_visible",
                                  "level_redraw", "score_redraw"};

    function automatic int clamp_to(input int v, input int hi);
        if (v < 0) begin
            return 0;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic int roll_toward(input int cur, input int goal);
        int diff;
        int step;
        diff = goal - cur;
        if (diff == 0) begin
            return cur;
        end
        step = diff / 6;
        if (step == 0) begin
            step = (diff > 0) ? 1 : -1;
        end
        return cur + step;
    endfunction

    function automatic t_disp predict_display(input int lvl_raw, input int scr_raw,
                                              input logic rst);
        int   lvl;
        int   scr;
        int   nxt;
        logic lred;
        logic sred;
        logic vis;
        lvl  = clamp_to(lvl_raw, int'(LEVEL_MAX));
        scr  = clamp_to(scr_raw, int'(SCORE_MAX));
        lred = 1'b0;
        sred = 1'b0;
        vis  = 1'b1;
        if (rst) begin
            primed     = 1'b0;
            blink_left = '0;
        end
        frame_no = frame_no + 5'd1;
        if (!primed) begin
            lvl_now  = lvl;
            lvl_goal = lvl;
            scr_now  = scr;
            scr_goal = scr;
            lred     = 1'b1;
            sred     = 1'b1;
            primed   = 1'b1;
        end
        if (lvl < lvl_goal) begin
            blink_left = 6'(blink_len);
        end
        lvl_goal = lvl;
        scr_goal = scr;
        nxt = roll_toward(lvl_now, lvl_goal);
        if (nxt != lvl_now) begin
            lvl_now = nxt;
            lred    = 1'b1;
        end
        nxt = roll_toward(scr_now, scr_goal);
        if (nxt != scr_now) begin
            scr_now = nxt;
            sred    = 1'b1;
        end
        if (blink_left != 0) begin
            blink_left = blink_left - 6'd1;
            vis        = !blink_left[1];
        end else if (lvl_goal > 0 && lvl_goal <= blink_thresh) begin
            vis = !frame_no[4];
        end
        return {4'(lvl_now / 100 % 10), 4'(lvl_now / 10 % 10), 4'(lvl_now % 10),
                4'(scr_now / 100000 % 10), 4'(scr_now / 10000 % 10),
                4'(scr_now / 1000 % 10), 4'(scr_now / 100 % 10),
                4'(scr_now / 10 % 10), 4'(scr_now % 10),
                {3'b000, vis}, {3'b000, lred}, {3'b000, sred}};
    endfunction

    function automatic t_frame_row table_row(input int lvl, input int scr, input bit rst,
                                             input bit has_want, input t_disp want);
        t_frame_row row;
        row.lvl      = 16'(lvl);
        row.scr      = 24'(scr);
        row.rst      = rst;
        row.has_want = has_want;
        row.want     = want;
        return row;
    endfunction

    task automatic offer_frame(input logic signed [15:0] lvl, input logic signed [23:0] scr,
                               input logic rst, input bit has_want, input t_disp want);
        t_disp predicted;
        while (!steady && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_level_raw <= lvl;
        i_score_raw <= scr;
        i_restart   <= rst;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predicted = predict_display(lvl, scr, rst);
        pending_displays.insert(pending_displays.size(), has_want ? want : predicted);
    endtask

    task automatic drain_and_pause();
        i_in_valid <= 1'b0;
        while (pending_displays.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_config(input int thresh, input int flen);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LOW_LEVEL;
        i_cfg_data <= CFG_DATA_W'(thresh);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FLASH_LEN;
        i_cfg_data <= {4'($urandom), 6'(flen)};
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        blink_thresh = thresh;
        blink_len    = flen;
    endtask

    // receiver: random backpressure, two long hold-offs, check each transfer
    initial begin
        t_disp got;
        t_disp want;
        int    stall_left;
        int    hold_offs;
        stall_left = 0;
        hold_offs  = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready) begin
                results_seen++;
                got = {o_level_hundreds, o_level_tens, o_level_ones,
                       o_score_d5, o_score_d4, o_score_d3, o_score_d2, o_score_d1, o_score_d0,
                       {3'b000, o_level_visible}, {3'b000, o_level_redraw},
                       {3'b000, o_score_redraw}};
                if (pending_displays.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                end else begin
                    want = pending_displays.pop_front();
                    for (int f = 0; f < 12; f++) begin
                        if (got[f] !== want[f]) begin
                            mismatches++;
                            $display("%0t: %s expected %0d actual %0d", $time,
                                     field_names[f], want[f], got[f]);
                        end
                    end
                end
            end
            if (stall_left == 0 && ((hold_offs == 0 && results_seen >= 150) ||
                                    (hold_offs == 1 && results_seen >= 1000))) begin
                hold_offs++;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= steady || ($urandom_range(99) >= 23);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready === 1'b1) ||
                (o_out_valid === 1'b1 && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        logic signed [15:0] lvl;
        logic signed [23:0] scr;
        logic               rst;
        int                 pick;
        directed[0]  = table_row(999, 999999, 1'b0, 1'b1, ALL_NINES);
        directed[1]  = table_row(0, 0, 1'b0, 1'b0, '0);
        directed[2]  = table_row(0, 0, 1'b0, 1'b0, '0);
        directed[3]  = table_row(0, 0, 1'b0, 1'b0, '0);
        directed[4]  = table_row(-32768, -8388608, 1'b1, 1'b1, ALL_ZEROS);
        directed[5]  = table_row(32767, 8388607, 1'b1, 1'b1, ALL_NINES);
        directed[6]  = table_row(1000, 1000000, 1'b0, 1'b0, '0);
        directed[7]  = table_row(-1, -1, 1'b0, 1'b0, '0);
        directed[8]  = table_row(1, 1, 1'b1, 1'b0, '0);
        directed[9]  = table_row(25, 999998, 1'b0, 1'b0, '0);
        directed[10] = table_row(26, 999999, 1'b0, 1'b0, '0);
        directed[11] = table_row(25, 0, 1'b0, 1'b0, '0);
        directed[12] = table_row(25, 0, 1'b1, 1'b0, '0);
        directed[13] = table_row(0, 0, 1'b1, 1'b1, ALL_ZEROS);
        directed[14] = table_row(7, 6, 1'b0, 1'b0, '0);
        directed[15] = table_row(7, 12, 1'b0, 1'b0, '0);
        directed[16] = table_row(500, 123456, 1'b1, 1'b0, '0);
        directed[17] = table_row(499, 123455, 1'b0, 1'b0, '0);
        directed[18] = table_row(499, 123455, 1'b0, 1'b0, '0);
        directed[19] = table_row(998, 654321, 1'b0, 1'b0, '0);
        directed[20] = table_row(32767, -8388608, 1'b0, 1'b0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain_and_pause();
                case (phase)
                    1: write_config(0, 0);
                    2: write_config(1023, 63);
                    3: write_config(999, 1);
                    4: write_config(1, 2);
                    7: write_config(25, 40);
                    default: write_config($urandom_range(1023), $urandom_range(63));
                endcase
            end
            steady = (phase == 2);
            if (phase == 0) begin
                for (int r = 0; r < DIRECTED_ROWS; r++) begin
                    offer_frame(directed[r].lvl, directed[r].scr, directed[r].rst,
                                directed[r].has_want, directed[r].want);
                end
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                rst  = 1'b0;
                if (pick < 5) begin
                    rst      = 1'b1;
                    walk_lvl = ($urandom_range(3) == 0) ? $urandom_range(1, 30)
                                                        : $urandom_range(0, 1000);
                    walk_scr = $urandom_range(0, 1000000);
                end else if (pick < 30) begin
                    walk_lvl = walk_lvl - $urandom_range(1, 50);
                end else if (pick < 55) begin
                    walk_lvl = walk_lvl + $urandom_range(1, 20);
                    walk_scr = walk_scr + $urandom_range(0, 20000);
                end
                if (walk_lvl < -20 || walk_lvl > 1100 || walk_scr > 1100000) begin
                    walk_lvl = $urandom_range(0, 60);
                    walk_scr = $urandom_range(0, 5000);
                end
                lvl = 16'(walk_lvl);
                scr = 24'(walk_scr);
                if (pick >= 90) begin
                    lvl = 16'($urandom);
                    scr = 24'($urandom);
                    rst = 1'($urandom);
                end
                offer_frame(lvl, scr, rst, 1'b0, '0);
            end
        end
        steady = 1'b0;
        drain_and_pause();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rcd_pkg.sv
rtl/core/rcd_frame_update.sv
rtl/core/rcd_digit_stage.sv
rtl/core/rolling_counter_display.sv
rtl/core/rcd_checker.sv
tb/sv/rolling_counter_display_tb.sv
